// File: rtl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants for the byte FIFO with message marks
// Sizes, operation codes, channel payloads and scan-unit interface structs.
// ----------------------------------------------------------------------------
package bfm_pkg;

	localparam int DEPTH  = 256;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CAP_W  = PTR_W + 1;    // holds DEPTH itself
	localparam int DIST_W = PTR_W + 2;    // signed-wrap room for distances
	localparam int CFG_W  = 9;
	localparam int OP_W   = 3;

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_MARK  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [7:0]      data_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       ok;
		logic       is_full;
		logic       is_empty;
		logic [8:0] fill_level;
		logic       mark_at_head;
		logic [8:0] to_mark_count;
		logic [7:0] since_mark_count;
		logic       since_mark_valid;
		logic [8:0] mark_total;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

	typedef struct packed {
		logic              have_fwd;
		logic [DIST_W-1:0] best_fwd;
		logic              have_back;
		logic [DIST_W-1:0] best_back;
		logic [CAP_W-1:0]  total;
	} scan_res_t;

	// Ring increment: wraps to zero when stepping to or past capacity.
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
		input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] sum;
		sum = {1'b0, p} + CAP_W'(1);
		return (sum >= cap) ? '0 : sum[PTR_W-1:0];
	endfunction

endpackage

// File: rtl/bfm_chan_if.sv
// ----------------------------------------------------------------------------
// bfm_chan_if: valid/ready channel
// Carries one payload per transfer; transfer when valid and ready are high.
// ----------------------------------------------------------------------------
interface bfm_chan_if #(parameter type payload_t = logic) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/byte_fifo_with_message_marks.sv
// ----------------------------------------------------------------------------
// byte_fifo_with_message_marks: ring byte FIFO with end-of-message marks
// Command-driven byte ring with one mark bit per entry and a mark scan.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : one command per transfer (operation, data_in). Write, read, peek,
//            mark last written byte, clear. Unused codes leave state alone.
//   out_ch : one status item per command (head byte, ok, flags, fill, marks).
//   cfg_we/cfg_wdata : capacity, written only while idle; clear after a change.
// Sequence
//   Executing, then reading each mark bit into the shared distance unit,
//   waiting for the last read to pass the unit, then forming the result in
//   the output register, which raises out_ch.valid.
//   in_ch.ready is high only between commands, once the last result is loaded.
// Reset
//   arst_n clears pointers, full flag, sequencer; capacity back to DEPTH, bytes
//   kept. A sweep over every entry then zeroes the mark bits, in_ch.ready low.
// Stall
//   The result waits in the output register; the next command is taken
//   meanwhile, but its result holds in the final step until out_ch drains.
// ----------------------------------------------------------------------------
module byte_fifo_with_message_marks
	import bfm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	bfm_chan_if.sink         in_ch,
	bfm_chan_if.source       out_ch
);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] cap_q;
	logic [PTR_W-1:0] rp_q, wp_q, lwp_q, idx_q;
	logic             full_q;
	logic             mark_mem [DEPTH];
	logic             mark_rd_s1, step_s1, head_mark_q;
	logic [PTR_W-1:0] idx_s1;
	logic [OP_W-1:0]  op_q;
	logic [7:0]       din_q, dout_q;
	logic             ok_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [CAP_W-1:0] eff_cap, fill_w;
	logic [PTR_W-1:0] wp_next, rp_next;
	logic             empty_now, in_take, out_load, store_we;
	logic             mark_we, mark_wdata, mark_seen;
	logic [PTR_W-1:0] mark_waddr;
	logic [7:0]       store_rdata;
	scan_ctl_t        scan_ctl;
	scan_res_t        scan_res;
	in_item_t         in_item;

	assign in_item = in_ch.payload;

	// Capacity clamp: zero acts as one, anything above the built depth as DEPTH.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CAP_W'(1);
		end else if (int'(cap_q) > DEPTH) begin
			eff_cap = CAP_W'(DEPTH);
		end else begin
			eff_cap = CAP_W'(cap_q);
		end
	end

	assign wp_next   = next_ptr(wp_q, eff_cap);
	assign rp_next   = next_ptr(rp_q, eff_cap);
	assign empty_now = (rp_q == wp_q) && !full_q;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_take     = in_ch.valid && (state_q == ST_IDLE);
	// wait for the last registered mark to leave the scan unit
	assign out_load    = (state_q == ST_DONE) && !step_s1 && (!out_valid_q || out_ch.ready);
	assign store_we    = (state_q == ST_EXEC) && (op_q == OP_WRITE) && !full_q;

	// fill level in modular CAP_W arithmetic
	always_comb begin
		if (full_q) begin
			fill_w = eff_cap;
		end else if (rp_q == wp_q) begin
			fill_w = '0;
		end else if (wp_q > rp_q) begin
			fill_w = CAP_W'(wp_q) - CAP_W'(rp_q);
		end else begin
			fill_w = eff_cap - CAP_W'(rp_q) + CAP_W'(wp_q);
		end
	end

	bfm_store u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (wp_q),
		.wdata (din_q),
		.raddr (rp_q),
		.rdata (store_rdata)
	);

	// Mark bit write port: reset sweep, head clear on read, mark of the last
	// written entry, and the sweep of a clear riding along with the scan.
	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = idx_q;
		mark_wdata = 1'b0;
		case (state_q)
			ST_INIT: begin
				mark_we = 1'b1;
			end
			ST_EXEC: begin
				if (op_q == OP_READ) begin
					mark_we    = 1'b1;
					mark_waddr = rp_q;
				end else if ((op_q == OP_MARK) && !empty_now) begin
					mark_we    = 1'b1;
					mark_waddr = lwp_q;
					mark_wdata = 1'b1;
				end
			end
			ST_SCAN: begin
				mark_we = (op_q == OP_CLEAR);
			end
			default: begin
			end
		endcase
	end

	// mark bits, one registered read per cycle at the scan index
	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		mark_rd_s1 <= mark_mem[idx_q];
	end

	// a clear wipes marks during its own scan, so old bits read as zero
	assign mark_seen = mark_rd_s1 && (op_q != OP_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1     <= 1'b0;
			idx_s1      <= '0;
			head_mark_q <= 1'b0;
		end else begin
			step_s1 <= (state_q == ST_SCAN);
			idx_s1  <= idx_q;
			if (step_s1 && (idx_s1 == rp_q)) begin
				head_mark_q <= mark_seen;
			end
		end
	end

	assign scan_ctl.clear = (state_q == ST_EXEC);
	assign scan_ctl.step  = step_s1;

	bfm_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (idx_s1),
		.mark     (mark_seen),
		.read_ptr (rp_q),
		.last_ptr (lwp_q),
		.cap      (eff_cap),
		.res      (scan_res)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CFG_W'(DEPTH);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// sequencer and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			rp_q    <= '0;
			wp_q    <= '0;
			lwp_q   <= '0;
			full_q  <= 1'b0;
			idx_q   <= '0;
			op_q    <= OP_PEEK;
			din_q   <= '0;
			dout_q  <= '0;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + PTR_W'(1);
					if (idx_q == PTR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						op_q    <= in_item.operation;
						din_q   <= in_item.data_in;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					dout_q  <= '0;
					ok_q    <= 1'b0;
					idx_q   <= '0;
					state_q <= ST_SCAN;
					case (op_q)
						OP_WRITE: begin
							if (!full_q) begin
								lwp_q  <= wp_q;
								wp_q   <= wp_next;
								full_q <= (wp_next == rp_q);
								ok_q   <= 1'b1;
							end
						end
						OP_READ: begin
							dout_q <= store_rdata;
							if (!empty_now) begin
								rp_q <= rp_next;
								ok_q <= 1'b1;
							end
							full_q <= 1'b0;
						end
						OP_PEEK: begin
							dout_q <= store_rdata;
						end
						OP_MARK: begin
							if (!empty_now) begin
								ok_q <= 1'b1;
							end
						end
						OP_CLEAR: begin
							rp_q   <= '0;
							wp_q   <= '0;
							lwp_q  <= '0;
							full_q <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				ST_SCAN: begin
					idx_q <= idx_q + PTR_W'(1);
					if (idx_q == PTR_W'(DEPTH - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: holds the result until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_load) begin
			out_valid_q            <= 1'b1;
			out_q.data_out         <= dout_q;
			out_q.ok               <= ok_q;
			out_q.is_full          <= full_q;
			out_q.is_empty         <= empty_now;
			out_q.fill_level       <= 9'(fill_w);
			out_q.mark_at_head     <= head_mark_q;
			out_q.to_mark_count    <= scan_res.have_fwd ?
				9'(scan_res.best_fwd + DIST_W'(1)) : 9'd0;
			out_q.since_mark_count <= scan_res.have_back ?
				8'(scan_res.best_back) : 8'd0;
			out_q.since_mark_valid <= scan_res.have_back;
			out_q.mark_total       <= 9'(scan_res.total);
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

endmodule

// File: rtl/bfm_store.sv
// ----------------------------------------------------------------------------
// bfm_store: byte storage of the ring
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfm_store
	import bfm_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [PTR_W-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic [PTR_W-1:0] raddr,
	output logic [7:0]       rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/bfm_scan.sv
// ----------------------------------------------------------------------------
// bfm_scan: mark distance unit
// Takes one ring entry per step, forms its forward and backward distances and
// keeps the running minimum of each plus the count of marks seen.
// ----------------------------------------------------------------------------
module bfm_scan
	import bfm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  logic [PTR_W-1:0] idx,
	input  logic             mark,
	input  logic [PTR_W-1:0] read_ptr,
	input  logic [PTR_W-1:0] last_ptr,
	input  logic [CAP_W-1:0] cap,
	output scan_res_t        res
);

	logic [DIST_W-1:0] idx_w, rp_w, lp_w, cap_w, fwd, back;
	scan_res_t         res_q;

	// Distances go negative when pointers sit past a shrunk capacity; in
	// DIST_W bits those compare above every non-negative value, as wide
	// unsigned arithmetic would.
	always_comb begin
		idx_w = DIST_W'(idx);
		rp_w  = DIST_W'(read_ptr);
		lp_w  = DIST_W'(last_ptr);
		cap_w = DIST_W'(cap);
		fwd   = (idx >= read_ptr) ? idx_w - rp_w : idx_w + cap_w - rp_w;
		back  = (idx <= last_ptr) ? lp_w - idx_w : cap_w - (idx_w - lp_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (ctl.clear) begin
			res_q <= '0;
		end else if (ctl.step && mark) begin
			res_q.total <= res_q.total + CAP_W'(1);
			// strict compare: lowest index wins a tie
			if (!res_q.have_fwd || fwd < res_q.best_fwd) begin
				res_q.have_fwd <= 1'b1;
				res_q.best_fwd <= fwd;
			end
			if (!res_q.have_back || back < res_q.best_back) begin
				res_q.have_back <= 1'b1;
				res_q.best_back <= back;
			end
		end
	end

	assign res = res_q;

endmodule

// File: tb/byte_fifo_with_message_marks_checker.sv
// ----------------------------------------------------------------------------
// byte_fifo_with_message_marks_checker: status scoreboard for the marked ring
// Watches the command and status channels and the capacity port. Keeps its
// own copy of the ring and compares every status transfer field by field.
// ----------------------------------------------------------------------------
module byte_fifo_with_message_marks_checker
	import bfm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             cmd_valid,
	input  logic             cmd_ready,
	input  in_item_t         cmd,
	input  logic             status_valid,
	input  logic             status_ready,
	input  out_item_t        status,
	output int unsigned      errors,
	output int unsigned      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SHOW_LIMIT = 40;

	logic [7:0]  ring_bytes [DEPTH];
	bit          ring_marks [DEPTH];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	int unsigned last_wr;
	int unsigned capacity;
	bit          ring_full;
	out_item_t   status_due [$];
	int unsigned statuses_seen;

	// 0 acts as 1, anything above the built depth as the depth
	function automatic int unsigned live_cap();
		if (capacity == 0) return 1;
		if (capacity > DEPTH) return DEPTH;
		return capacity;
	endfunction

	function automatic int unsigned advance(input int unsigned p, input int unsigned cap);
		return (p + 1 >= cap) ? 0 : p + 1;
	endfunction

	function automatic bit ring_empty();
		return (rd_ptr == wr_ptr) && !ring_full;
	endfunction

	// Applies one command to the shadow ring and returns the status it gives.
	function automatic out_item_t ring_step(input in_item_t c);
		out_item_t   r;
		int unsigned cap;
		int unsigned idx;
		int unsigned fwd;
		int unsigned back;
		int unsigned best_fwd;
		int unsigned best_back;
		int unsigned marks_set;
		int unsigned fill;
		bit          have;
		cap = live_cap();
		r   = '0;
		case (c.operation)
			OP_WRITE: begin
				if (!ring_full) begin
					last_wr             = wr_ptr;
					ring_bytes[wr_ptr]  = c.data_in;
					wr_ptr              = advance(wr_ptr, cap);
					ring_full           = (wr_ptr == rd_ptr);
					r.ok                = 1'b1;
				end
			end
			OP_READ: begin
				// head mark drops even when nothing is read out
				r.data_out         = ring_bytes[rd_ptr];
				ring_marks[rd_ptr] = 1'b0;
				if (!ring_empty()) begin
					rd_ptr = advance(rd_ptr, cap);
					r.ok   = 1'b1;
				end
				ring_full = 1'b0;
			end
			OP_PEEK: begin
				r.data_out = ring_bytes[rd_ptr];
			end
			OP_MARK: begin
				if (!ring_empty()) begin
					ring_marks[last_wr] = 1'b1;
					r.ok                = 1'b1;
				end
			end
			OP_CLEAR: begin
				rd_ptr     = 0;
				wr_ptr     = 0;
				last_wr    = 0;
				ring_full  = 1'b0;
				ring_marks = '{default: 1'b0};
			end
			default: begin
			end
		endcase

		// Scan every entry; distances wrap as 32-bit unsigned, lowest index wins ties.
		have      = 1'b0;
		marks_set = 0;
		best_fwd  = 0;
		best_back = 0;
		for (idx = 0; idx < DEPTH; idx++) begin
			if (ring_marks[idx]) begin
				marks_set++;
				fwd  = (idx >= rd_ptr) ? idx - rd_ptr : idx + cap - rd_ptr;
				back = (idx <= last_wr) ? last_wr - idx : cap - (idx - last_wr);
				if (!have || fwd < best_fwd) best_fwd = fwd;
				if (!have || back < best_back) best_back = back;
				have = 1'b1;
			end
		end

		if (ring_full) fill = cap;
		else if (rd_ptr == wr_ptr) fill = 0;
		else if (wr_ptr > rd_ptr) fill = wr_ptr - rd_ptr;
		else fill = cap - rd_ptr + wr_ptr;

		r.is_full          = ring_full;
		r.is_empty         = ring_empty();
		r.fill_level       = 9'(fill);
		r.mark_at_head     = ring_marks[rd_ptr];
		r.to_mark_count    = have ? 9'(best_fwd + 1) : 9'd0;
		r.since_mark_count = have ? 8'(best_back) : 8'd0;
		r.since_mark_valid = have;
		r.mark_total       = 9'(marks_set);
		return r;
	endfunction

	task automatic flag_error(input string what);
		errors++;
		if (errors <= SHOW_LIMIT)
			$display("ERROR at %0t ns, status %0d: %s", $time, statuses_seen, what);
	endtask

	task automatic check_status(input out_item_t want, input out_item_t got);
		if (got.data_out !== want.data_out)
			flag_error($sformatf("data_out %0h, expected %0h", got.data_out, want.data_out));
		if (got.ok !== want.ok)
			flag_error($sformatf("ok %0b, expected %0b", got.ok, want.ok));
		if (got.is_full !== want.is_full)
			flag_error($sformatf("is_full %0b, expected %0b", got.is_full, want.is_full));
		if (got.is_empty !== want.is_empty)
			flag_error($sformatf("is_empty %0b, expected %0b", got.is_empty, want.is_empty));
		if (got.fill_level !== want.fill_level)
			flag_error($sformatf("fill_level %0d, expected %0d",
				got.fill_level, want.fill_level));
		if (got.mark_at_head !== want.mark_at_head)
			flag_error($sformatf("mark_at_head %0b, expected %0b",
				got.mark_at_head, want.mark_at_head));
		if (got.to_mark_count !== want.to_mark_count)
			flag_error($sformatf("to_mark_count %0d, expected %0d",
				got.to_mark_count, want.to_mark_count));
		if (got.since_mark_count !== want.since_mark_count)
			flag_error($sformatf("since_mark_count %0d, expected %0d",
				got.since_mark_count, want.since_mark_count));
		if (got.since_mark_valid !== want.since_mark_valid)
			flag_error($sformatf("since_mark_valid %0b, expected %0b",
				got.since_mark_valid, want.since_mark_valid));
		if (got.mark_total !== want.mark_total)
			flag_error($sformatf("mark_total %0d, expected %0d",
				got.mark_total, want.mark_total));
	endtask

	// Status transfer is handled before the command transfer of the same edge,
	// so a status can never be matched against the command just taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr        = 0;
			wr_ptr        = 0;
			last_wr       = 0;
			ring_full     = 1'b0;
			capacity      = DEPTH;
			ring_marks    = '{default: 1'b0};
			ring_bytes    = '{default: 8'h00};
			statuses_seen = 0;
			errors        = 0;
			status_due.delete();
			pending      <= 0;
		end else begin
			if (status_valid && status_ready) begin
				if (status_due.size() == 0)
					flag_error("status transfer with no command outstanding");
				else
					check_status(status_due.pop_front(), status);
				statuses_seen++;
			end
			if (cfg_we) capacity = cfg_wdata;
			if (cmd_valid && cmd_ready) status_due.push_back(ring_step(cmd));
			pending <= status_due.size();
		end
	end

endmodule

// File: tb/byte_fifo_with_message_marks_tb.sv
// ----------------------------------------------------------------------------
// byte_fifo_with_message_marks_tb: testbench top for the marked byte ring
// Drives commands and capacity writes, throttles the status channel, and
// reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module byte_fifo_with_message_marks_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfm_pkg::*;

	// Longest quiet stretch is a long status stall on top of the scan; the
	// limit leaves a wide margin.
	localparam int unsigned STALL_LIMIT  = 6000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS  = 40;
	localparam int unsigned PHASES       = 12;

	// codes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	bfm_chan_if #(.payload_t(in_item_t))  cmd_ch ();
	bfm_chan_if #(.payload_t(out_item_t)) status_ch ();

	int unsigned fail_count;
	int unsigned results_due;
	int unsigned commands_sent;
	int unsigned config_writes;
	bit          no_idle;

	byte_fifo_with_message_marks uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (cmd_ch),
		.out_ch    (status_ch)
	);

	byte_fifo_with_message_marks_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd_valid    (cmd_ch.valid),
		.cmd_ready    (cmd_ch.ready),
		.cmd          (cmd_ch.payload),
		.status_valid (status_ch.valid),
		.status_ready (status_ch.ready),
		.status       (status_ch.payload),
		.errors       (fail_count),
		.pending      (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none in steady phases.
	function automatic int unsigned idle_span();
		if (no_idle) return 0;
		if ($urandom_range(0, 11) == 0) return $urandom_range(40, 400);
		return $urandom_range(0, 3);
	endfunction

	// One command transfer. Valid stays high on return so back-to-back
	// commands never lower and raise it in the same step.
	task automatic issue(input logic [OP_W-1:0] op, input logic [7:0] din);
		int unsigned gap;
		gap = idle_span();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= '{operation: op, data_in: din};
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		commands_sent++;
	endtask

	// Capacity changes only with the block idle: the write waits until every
	// status is back.
	task automatic set_capacity(input logic [CFG_W-1:0] value);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		config_writes++;
	endtask

	// Status side: ready high for a stretch, then a stall unless steady.
	initial begin
		int unsigned hold;
		status_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			status_ch.ready <= 1'b1;
			hold = $urandom_range(1, 40);
			repeat (hold) @(posedge clk);
			hold = idle_span();
			if (hold != 0) begin
				status_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned cap_plan [PHASES];
		int unsigned phase;
		int unsigned start;
		int unsigned len;
		int unsigned pick;
		int unsigned msg_max;
		int unsigned k;

		cmd_ch.valid   = 1'b0;
		cmd_ch.payload = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		arst_n         = 1'b0;
		no_idle        = 1'b0;
		commands_sent  = 0;
		config_writes  = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part, capacity at its reset value of 256 ---
		// Only entries already written are ever read or peeked.
		issue(OP_MARK, 8'h00);         // mark on empty ring: refused
		issue(OP_SPARE_5, 8'hff);      // unused codes leave the ring alone
		issue(OP_SPARE_6, 8'h00);
		issue(OP_SPARE_7, 8'hff);
		issue(OP_WRITE, 8'h00);
		issue(OP_WRITE, 8'hff);
		issue(OP_MARK, 8'hff);         // mark on entry 1
		issue(OP_PEEK, 8'h00);
		issue(OP_READ, 8'h00);
		issue(OP_READ, 8'h00);         // reads entry 1, drops its mark
		issue(OP_CLEAR, 8'hff);
		issue(OP_READ, 8'hff);         // read on empty ring: entry 0, no advance
		issue(OP_PEEK, 8'h00);
		issue(OP_WRITE, 8'h5a);
		issue(OP_MARK, 8'h00);
		issue(OP_WRITE, 8'ha5);
		issue(OP_WRITE, 8'h3c);
		issue(OP_MARK, 8'h00);
		issue(OP_WRITE, 8'hc3);
		issue(OP_READ, 8'h00);

		// shrink to one entry without a clear: pointers past the end wrap
		set_capacity(CFG_W'(1));
		issue(OP_READ, 8'h00);
		issue(OP_CLEAR, 8'h00);
		issue(OP_WRITE, 8'h81);        // ring now full
		issue(OP_WRITE, 8'h7e);        // refused while full
		issue(OP_MARK, 8'h00);
		issue(OP_READ, 8'h00);
		issue(OP_READ, 8'h00);         // empty again

		// --- fill the whole store once; later reads then never hit unwritten data ---
		set_capacity(CFG_W'(DEPTH));
		issue(OP_CLEAR, 8'h00);
		for (k = 0; k < DEPTH; k++) issue(OP_WRITE, 8'($urandom));
		issue(OP_WRITE, 8'($urandom)); // refused at full depth
		issue(OP_MARK, 8'($urandom));  // mark on the last entry
		issue(OP_PEEK, 8'($urandom));

		// --- random phases over the capacity range ---
		// 0 and values above the depth probe clamping; every few phases the
		// clear after a capacity change is left out on purpose.
		cap_plan = '{2, 3, 0, 5, 16, 1, 511, 256, 4, 300, 7, 255};
		for (phase = 0; phase < PHASES; phase++) begin
			no_idle = (phase % 3 == 1);
			set_capacity(CFG_W'(cap_plan[phase]));
			if (phase % 4 != 2) issue(OP_CLEAR, 8'($urandom));
			msg_max = (cap_plan[phase] >= 100) ? 20 : 6;
			start   = commands_sent;
			while (commands_sent - start < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// a message: bytes, usually closed by a mark
					len = (msg_max == 20 && $urandom_range(0, 9) == 0) ?
						$urandom_range(30, 90) : $urandom_range(1, msg_max);
					for (k = 0; k < len; k++) issue(OP_WRITE, 8'($urandom));
					if ($urandom_range(0, 5) != 0) issue(OP_MARK, 8'($urandom));
				end else if (pick < 85) begin
					// drain, with a peek here and there
					len = $urandom_range(1, msg_max);
					for (k = 0; k < len; k++)
						issue(($urandom_range(0, 4) == 0) ? OP_PEEK : OP_READ,
							8'($urandom));
				end else begin
					// noise: any code, unused ones included
					issue(OP_W'($urandom_range(0, 7)), 8'($urandom));
				end
			end
		end

		// --- wind down: all statuses back, then watch for strays ---
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands under %0d capacity writes (0, 1, 256, above depth)",
			commands_sent, config_writes);
		$display("including full and empty rings, refused writes and marks, spare codes");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
